### rtl/websocket_frame_deframer_assert.svh
// Assertion macros for the WebSocket deframer, clocked on clk_i and held off during reset.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define WSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication.
`define WSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic {
    ERR_FRAGMENTED = 1'b0,
    ERR_TOO_LONG   = 1'b1
  } err_e;

  localparam logic [6:0]  LEN16_CODE   = 7'd126;
  localparam logic [6:0]  LEN64_CODE   = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN = 64'd125;
  localparam logic [2:0]  LEN16_LEFT   = 3'd1;
  localparam logic [2:0]  LEN64_LEFT   = 3'd7;
  localparam logic [2:0]  KEY_LEFT     = 3'd3;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        final_fragment;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [63:0] payload_length;
    err_e        error_code;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

### rtl/wsd_parse.sv
// Frame parser: header, extended length, masking key and payload unmasking, one byte a cycle while beat_i is high.
module wsd_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           beat_i,
  input  logic [7:0]     rx_byte_i,
  output wsd_pkg::push_t push_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      hdr_q, hdr_d;
  logic            mask_q, mask_d;
  logic [63:0]     acc_q, acc_d;
  logic [2:0]      left_q, left_d;
  logic [3:0][7:0] key_q, key_d;
  logic [63:0]     rem_q, rem_d;
  logic [1:0]      kidx_q, kidx_d;
  logic            drop_q, drop_d;

  logic            after_len;
  logic            finish;
  logic            hdr_last;
  logic            pay_last;
  logic            ctrl_fault;
  logic [6:0]      len7;
  logic [7:0]      key_byte;

  assign len7     = rx_byte_i[6:0];
  assign key_byte = mask_q ? key_q[2'd3 - kidx_q] : 8'd0;

  // control frame: fragmented or too long gets an error, payload dropped
  assign ctrl_fault = hdr_q[3] && (!hdr_q[7] || acc_d > wsd_pkg::CTRL_MAX_LEN);

  // next state
  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    mask_d    = mask_q;
    acc_d     = acc_q;
    left_d    = left_q;
    key_d     = key_q;
    rem_d     = rem_q;
    kidx_d    = kidx_q;
    drop_d    = drop_q;
    after_len = 1'b0;
    finish    = 1'b0;
    hdr_last  = 1'b0;
    pay_last  = 1'b0;

    if (beat_i) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR1: begin
          mask_d = rx_byte_i[7];
          if (len7 == wsd_pkg::LEN16_CODE) begin
            acc_d   = 64'd0;
            left_d  = wsd_pkg::LEN16_LEFT;
            phase_d = wsd_pkg::PH_EXTLEN;
          end else if (len7 == wsd_pkg::LEN64_CODE) begin
            acc_d   = 64'd0;
            left_d  = wsd_pkg::LEN64_LEFT;
            phase_d = wsd_pkg::PH_EXTLEN;
          end else begin
            acc_d     = {57'd0, len7};
            after_len = 1'b1;
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          acc_d = {acc_q[55:0], rx_byte_i};
          if (left_q != 3'd0) begin
            left_d = left_q - 3'd1;
          end else begin
            after_len = 1'b1;
          end
        end
        wsd_pkg::PH_KEY: begin
          key_d = {key_q[2:0], rx_byte_i};
          if (left_q != 3'd0) begin
            left_d = left_q - 3'd1;
          end else begin
            finish = 1'b1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          rem_d    = rem_q - 64'd1;
          kidx_d   = kidx_q + 2'd1;
          pay_last = (rem_q == 64'd1);
          if (pay_last) begin
            phase_d = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          hdr_d   = rx_byte_i;
          phase_d = wsd_pkg::PH_HDR1;
        end
      endcase
    end

    if (after_len) begin
      key_d = '0;
      if (mask_d) begin
        phase_d = wsd_pkg::PH_KEY;
        left_d  = wsd_pkg::KEY_LEFT;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      rem_d    = acc_d;
      kidx_d   = 2'd0;
      drop_d   = ctrl_fault;
      hdr_last = (acc_d == 64'd0);
      phase_d  = hdr_last ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
    end
  end

  // result for this beat
  always_comb begin
    push_o.valid             = 1'b0;
    push_o.res.kind          = wsd_pkg::KIND_HEADER;
    push_o.res.payload_byte  = 8'd0;
    push_o.res.error_code    = wsd_pkg::ERR_FRAGMENTED;
    push_o.res.last_of_frame = 1'b0;

    if (beat_i && (phase_q == wsd_pkg::PH_PAYLOAD) && !drop_q) begin
      push_o.valid             = 1'b1;
      push_o.res.kind          = wsd_pkg::KIND_PAYLOAD;
      push_o.res.payload_byte  = rx_byte_i ^ key_byte;
      push_o.res.last_of_frame = pay_last;
    end

    if (finish) begin
      push_o.valid = 1'b1;
      if (ctrl_fault) begin
        push_o.res.kind          = wsd_pkg::KIND_ERROR;
        push_o.res.error_code    = hdr_q[7] ? wsd_pkg::ERR_TOO_LONG
                                            : wsd_pkg::ERR_FRAGMENTED;
        push_o.res.last_of_frame = 1'b1;
      end else begin
        push_o.res.kind          = wsd_pkg::KIND_HEADER;
        push_o.res.last_of_frame = hdr_last;
      end
    end

    push_o.res.final_fragment = hdr_q[7];
    push_o.res.reserved_bits  = hdr_q[6:4];
    push_o.res.frame_opcode   = hdr_q[3:0];
    push_o.res.was_masked     = mask_d;
    push_o.res.payload_length = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsd_pkg::PH_HDR0;
      hdr_q   <= 8'd0;
      mask_q  <= 1'b0;
      acc_q   <= 64'd0;
      left_q  <= 3'd0;
      key_q   <= '0;
      rem_q   <= 64'd0;
      kidx_q  <= 2'd0;
      drop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      mask_q  <= mask_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      key_q   <= key_d;
      rem_q   <= rem_d;
      kidx_q  <= kidx_d;
      drop_q  <= drop_d;
    end
  end

endmodule

### rtl/wsd_out_buf.sv
// Two-entry result register: output stage plus skid entry.
module wsd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsd_pkg::push_t   push_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wsd_pkg::result_t out_res_o
);

  logic             main_v_q, main_v_d;
  logic             skid_v_q, skid_v_d;
  wsd_pkg::result_t main_q, main_d;
  wsd_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop         = main_v_q && !out_stall_i;
  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_res_o   = main_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      // input is held off while the skid entry is full
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i.valid) begin
      if (!main_v_q || pop) begin
        main_d   = push_i.res;
        main_v_d = 1'b1;
      end else begin
        skid_d   = push_i.res;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

### rtl/websocket_frame_deframer.sv
// Top level of the WebSocket receive deframer.
//
//   channel | direction | handshake                  | beat
//   in      | sink      | in_valid_i / in_stall_o    | rx_byte_i
//   out     | source    | out_valid_o / out_stall_i  | kind_o .. last_of_frame_o
//
// One input beat per cycle while in_stall_o is low; its result (if any) is registered into the output stage.
// All per-byte work is one pass through the parser between its state and the result register.
// Reset (rst_ni low, asynchronous) returns the parser to the first header byte and empties
// the output stage.
// The output stage holds two results; in_stall_o rises only when both are occupied.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        final_fragment_o,
  output logic [2:0]  reserved_bits_o,
  output logic [3:0]  frame_opcode_o,
  output logic        was_masked_o,
  output logic [63:0] payload_length_o,
  output logic        error_code_o,
  output logic        last_of_frame_o
);

  logic             beat;
  logic             full;
  wsd_pkg::push_t   push;
  wsd_pkg::result_t res;

  assign beat       = in_valid_i && !full;
  assign in_stall_o = full;

  wsd_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .push_o    (push)
  );

  wsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign kind_o           = res.kind;
  assign payload_byte_o   = res.payload_byte;
  assign final_fragment_o = res.final_fragment;
  assign reserved_bits_o  = res.reserved_bits;
  assign frame_opcode_o   = res.frame_opcode;
  assign was_masked_o     = res.was_masked;
  assign payload_length_o = res.payload_length;
  assign error_code_o     = res.error_code;
  assign last_of_frame_o  = res.last_of_frame;

`include "websocket_frame_deframer_assert.svh"

  `WSD_ASSERT_IMP(a_stall_needs_out, in_stall_o, out_valid_o)
  `WSD_ASSERT_IMP(a_err_is_last, out_valid_o && kind_o == wsd_pkg::KIND_ERROR, last_of_frame_o)
  `WSD_ASSERT_IMP(a_stall_rise, $rose(in_stall_o), $past(out_stall_i))
  `WSD_ASSERT_NXT(a_skid_drains, in_stall_o && !out_stall_i, !in_stall_o)

endmodule

### verif/ws_deframe_checker.sv
// Scoreboard for the WebSocket deframer: watches both channels, predicts results, compares beats.
module ws_deframe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        final_fragment_i,
  input  logic [2:0]  reserved_bits_i,
  input  logic [3:0]  frame_opcode_i,
  input  logic        was_masked_i,
  input  logic [63:0] payload_length_i,
  input  logic        error_code_i,
  input  logic        last_of_frame_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          headers_o,
  output int          payload_beats_o,
  output int          errors_o
);

  // Parser state mirrored from the stream
  wsd_pkg::phase_e  phase;
  logic [7:0]       hdr0;
  logic             mask_on;
  logic [63:0]      len_acc;
  logic [2:0]       field_left;
  logic [31:0]      key;
  logic [63:0]      remaining;
  logic [1:0]       key_idx;
  logic             dropping;

  wsd_pkg::result_t deframed_q[$];
  int               mismatches;
  int               n_headers;
  int               n_payload;
  int               n_errors;

  function automatic wsd_pkg::result_t frame_result(wsd_pkg::kind_e k, logic [7:0] data,
                                                    wsd_pkg::err_e err, logic last);
    wsd_pkg::result_t r;
    r.kind           = k;
    r.payload_byte   = data;
    r.final_fragment = hdr0[7];
    r.reserved_bits  = hdr0[6:4];
    r.frame_opcode   = hdr0[3:0];
    r.was_masked     = mask_on;
    r.payload_length = len_acc;
    r.error_code     = err;
    r.last_of_frame  = last;
    return r;
  endfunction

  function automatic void expect_beat(wsd_pkg::result_t r);
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  task automatic close_header();
    logic last;
    remaining = len_acc;
    key_idx   = 2'd0;
    dropping  = 1'b0;
    last      = (len_acc == 64'd0);
    phase     = last ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
    // fragmentation wins when a control frame has both faults
    if (hdr0[3] && (!hdr0[7] || len_acc > wsd_pkg::CTRL_MAX_LEN)) begin
      dropping = 1'b1;
      expect_beat(frame_result(wsd_pkg::KIND_ERROR, 8'h00,
                               hdr0[7] ? wsd_pkg::ERR_TOO_LONG : wsd_pkg::ERR_FRAGMENTED,
                               1'b1));
    end else begin
      expect_beat(frame_result(wsd_pkg::KIND_HEADER, 8'h00, wsd_pkg::ERR_FRAGMENTED, last));
    end
  endtask

  task automatic length_done();
    key = 32'd0;
    if (mask_on) begin
      phase      = wsd_pkg::PH_KEY;
      field_left = wsd_pkg::KEY_LEFT;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] k;
    logic       last;
    case (phase)
      wsd_pkg::PH_HDR1: begin
        mask_on = b[7];
        if (b[6:0] == wsd_pkg::LEN16_CODE) begin
          len_acc    = 64'd0;
          field_left = wsd_pkg::LEN16_LEFT;
          phase      = wsd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsd_pkg::LEN64_CODE) begin
          len_acc    = 64'd0;
          field_left = wsd_pkg::LEN64_LEFT;
          phase      = wsd_pkg::PH_EXTLEN;
        end else begin
          len_acc = {57'd0, b[6:0]};
          length_done();
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        if (field_left != 3'd0) field_left = field_left - 3'd1;
        else length_done();
      end
      wsd_pkg::PH_KEY: begin
        key = {key[23:0], b};
        if (field_left != 3'd0) field_left = field_left - 3'd1;
        else close_header();
      end
      wsd_pkg::PH_PAYLOAD: begin
        // key byte 0 sits in the top byte
        k         = mask_on ? key[8*(3-key_idx) +: 8] : 8'h00;
        remaining = remaining - 64'd1;
        key_idx   = key_idx + 2'd1;
        last      = (remaining == 64'd0);
        if (last) phase = wsd_pkg::PH_HDR0;
        if (!dropping) begin
          expect_beat(frame_result(wsd_pkg::KIND_PAYLOAD, b ^ k, wsd_pkg::ERR_FRAGMENTED, last));
        end
      end
      default: begin
        hdr0  = b;
        phase = wsd_pkg::PH_HDR1;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    wsd_pkg::result_t got;
    wsd_pkg::result_t want;
    if (!rst_ni) begin
      phase      = wsd_pkg::PH_HDR0;
      hdr0       = 8'h00;
      mask_on    = 1'b0;
      len_acc    = 64'd0;
      field_left = 3'd0;
      key        = 32'd0;
      remaining  = 64'd0;
      key_idx    = 2'd0;
      dropping   = 1'b0;
      deframed_q.delete();
      mismatches = 0;
      n_headers  = 0;
      n_payload  = 0;
      n_errors   = 0;
      fail_count_o    <= 0;
      pending_o       <= 0;
      headers_o       <= 0;
      payload_beats_o <= 0;
      errors_o        <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.kind           = wsd_pkg::kind_e'(kind_i);
        got.payload_byte   = payload_byte_i;
        got.final_fragment = final_fragment_i;
        got.reserved_bits  = reserved_bits_i;
        got.frame_opcode   = frame_opcode_i;
        got.was_masked     = was_masked_i;
        got.payload_length = payload_length_i;
        got.error_code     = wsd_pkg::err_e'(error_code_i);
        got.last_of_frame  = last_of_frame_i;
        if (deframed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result beat: kind=%0d byte=%02h len=%0d",
                     $realtime, kind_i, payload_byte_i, payload_length_i);
        end else begin
          want = deframed_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display({"  expected: kind=%0d byte=%02h fin=%b rsv=%03b op=%h mask=%b",
                        " len=%0d err=%b last=%b"},
                       want.kind, want.payload_byte, want.final_fragment, want.reserved_bits,
                       want.frame_opcode, want.was_masked, want.payload_length,
                       want.error_code, want.last_of_frame);
              $display({"  actual:   kind=%0d byte=%02h fin=%b rsv=%03b op=%h mask=%b",
                        " len=%0d err=%b last=%b"},
                       got.kind, got.payload_byte, got.final_fragment, got.reserved_bits,
                       got.frame_opcode, got.was_masked, got.payload_length,
                       got.error_code, got.last_of_frame);
            end
          end
          case (want.kind)
            wsd_pkg::KIND_HEADER:  n_headers++;
            wsd_pkg::KIND_PAYLOAD: n_payload++;
            default:               n_errors++;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
      fail_count_o    <= mismatches;
      pending_o       <= deframed_q.size();
      headers_o       <= n_headers;
      payload_beats_o <= n_payload;
      errors_o        <= n_errors;
    end
  end

endmodule

### verif/websocket_frame_deframer_tb.sv
// Testbench top for the WebSocket deframer: frame stimulus, receiver stalls and the verdict.
module websocket_frame_deframer_tb;

  localparam int ITEM_TARGET = 950;
  localparam int CYCLE_LIMIT = 300000;

  localparam int FORM_7  = 0;
  localparam int FORM_16 = 1;
  localparam int FORM_64 = 2;

  localparam logic [3:0] OP_CONT      = 4'h0;
  localparam logic [3:0] OP_TEXT      = 4'h1;
  localparam logic [3:0] OP_BINARY    = 4'h2;
  localparam logic [3:0] OP_PING      = 4'h9;
  localparam logic [3:0] OP_PONG      = 4'hA;
  localparam logic [3:0] OP_CTRL_RSVD = 4'hF;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        final_fragment;
  logic [2:0]  reserved_bits;
  logic [3:0]  frame_opcode;
  logic        was_masked;
  logic [63:0] payload_length;
  logic        error_code;
  logic        last_of_frame;

  int fail_count;
  int pending;
  int headers;
  int payload_beats;
  int errors;

  int cycles      = 0;
  int bytes_sent  = 0;
  int frames_sent = 0;
  int burst_left  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  websocket_frame_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .payload_byte_o   (payload_byte),
    .final_fragment_o (final_fragment),
    .reserved_bits_o  (reserved_bits),
    .frame_opcode_o   (frame_opcode),
    .was_masked_o     (was_masked),
    .payload_length_o (payload_length),
    .error_code_o     (error_code),
    .last_of_frame_o  (last_of_frame)
  );

  ws_deframe_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .kind_i           (kind),
    .payload_byte_i   (payload_byte),
    .final_fragment_i (final_fragment),
    .reserved_bits_i  (reserved_bits),
    .frame_opcode_i   (frame_opcode),
    .was_masked_i     (was_masked),
    .payload_length_i (payload_length),
    .error_code_i     (error_code),
    .last_of_frame_i  (last_of_frame),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .headers_o        (headers),
    .payload_beats_o  (payload_beats),
    .errors_o         (errors)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: free flow, light, heavy periodic and coin-flip windows
  always @(posedge clk_i) begin
    case (cycles[10:9])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= (cycles[2:0] < 3'd5);
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic drive_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic masked, input int form, input logic [63:0] len,
                             input int n_payload);
    send_byte({fin, rsv, op});
    case (form)
      FORM_7: send_byte({masked, len[6:0]});
      FORM_16: begin
        send_byte({masked, wsd_pkg::LEN16_CODE});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wsd_pkg::LEN64_CODE});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) repeat (4) send_byte(8'($urandom));
    repeat (n_payload) send_byte(8'($urandom));
    frames_sent++;
  endtask

  task automatic random_frame();
    int          pick;
    int          form;
    logic [63:0] len;
    logic        fin;
    logic        masked;
    logic [2:0]  rsv;
    logic [3:0]  op;
    pick   = $urandom_range(0, 99);
    fin    = ($urandom_range(0, 3) != 0);
    masked = ($urandom_range(0, 9) < 7);
    rsv    = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd0;
    op     = {1'b0, 3'($urandom)};
    form   = FORM_7;
    len    = 64'($urandom_range(0, 20));
    if (pick < 50) begin
      // short data frame, defaults above
    end else if (pick < 65) begin
      form = FORM_16;
      len  = 64'($urandom_range(0, 160));
    end else if (pick < 73) begin
      form = FORM_64;
      len  = 64'($urandom_range(0, 40));
    end else if (pick < 88) begin
      op  = {1'b1, 3'($urandom)};
      fin = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? 64'd125 : 64'($urandom_range(0, 12));
    end else if (pick < 94) begin
      op  = {1'b1, 3'($urandom)};
      fin = 1'b0;
      len = 64'($urandom_range(0, 8));
    end else if (pick < 97) begin
      // oversized control frame, fragmented at times as well
      op   = {1'b1, 3'($urandom)};
      form = FORM_16;
      len  = 64'($urandom_range(126, 140));
    end else begin
      {fin, rsv, op} = 8'($urandom);
      masked = 1'($urandom);
      len    = 64'($urandom_range(0, 125));
    end
    drive_frame(fin, rsv, op, masked, form, len, int'(len));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    bit mid_drain;
    mid_drain = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_frame(1'b1, 3'b000, OP_PONG,      1'b1, FORM_7,  64'd0, 0);
    drive_frame(1'b1, 3'b000, OP_TEXT,      1'b1, FORM_7,  64'd2, 2);
    drive_frame(1'b0, 3'b000, OP_PING,      1'b0, FORM_7,  64'd0, 0);
    drive_frame(1'b1, 3'b111, OP_CTRL_RSVD, 1'b0, FORM_7,  64'd0, 0);
    drive_frame(1'b0, 3'b101, OP_CONT,      1'b0, FORM_16, 64'd1, 1);
    drain();

    while (bytes_sent < ITEM_TARGET) begin
      random_frame();
      if (!mid_drain && bytes_sent >= ITEM_TARGET / 2) begin
        drain();
        mid_drain = 1'b1;
      end
    end

    // huge length with the top bit set; the parser stays inside this payload
    drive_frame(1'b1, 3'b000, OP_BINARY, 1'b1, FORM_64, 64'hFFFF_FFFF_FFFF_FFF0, 12);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d frames with sender gaps and receiver stalls",
             bytes_sent, frames_sent);
    $display("Checked %0d headers, %0d payload beats, %0d protocol errors; %0d mismatches",
             headers, payload_beats, errors, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
